@@ hdl/nmea_rmc_position_extractor_top_defines.svh @@
// assertion helpers shared by the rtl, all sampled on clk with rst_n held low as disable
`ifndef NMEA_RMC_POSITION_EXTRACTOR_TOP_DEFINES_SVH
`define NMEA_RMC_POSITION_EXTRACTOR_TOP_DEFINES_SVH

// same-cycle implication
`define NRMC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nrmc assertion failed");

// next-cycle implication
`define NRMC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nrmc assertion failed");

`endif

@@ hdl/nrmc_pkg.sv @@
`default_nettype none
package nrmc_pkg;

  typedef enum logic [3:0] {
    PH_HUNT   = 4'd0,
    PH_G      = 4'd1,
    PH_P      = 4'd2,
    PH_R      = 4'd3,
    PH_M      = 4'd4,
    PH_C      = 4'd5,
    PH_SKIP1  = 4'd6,
    PH_SKIP2  = 4'd7,
    PH_STATUS = 4'd8,
    PH_SKIP3  = 4'd9,
    PH_LAT    = 4'd10,
    PH_SKIPL1 = 4'd11,
    PH_SKIPL2 = 4'd12,
    PH_LON    = 4'd13
  } phase_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_V      = 8'h56;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  typedef struct packed {
    logic       field_sel;
    logic [3:0] char_pos;
    logic [7:0] coord_char;
    logic       fix_valid;
    logic       last_of_sentence;
  } coord_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [7:0] header_char(input phase_t ph);
    logic [7:0] c;
    case (ph)
      PH_G:    c = CH_G;
      PH_P:    c = CH_P;
      PH_R:    c = CH_R;
      PH_M:    c = CH_M;
      default: c = CH_C;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ hdl/nrmc_if.sv @@
`default_nettype none
interface nrmc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface nrmc_out_if;
  logic       valid;
  logic       ready;
  logic       field_sel;
  logic [3:0] char_pos;
  logic [7:0] coord_char;
  logic       fix_valid;
  logic       last_of_sentence;
  modport source(output valid, output field_sel, output char_pos, output coord_char,
                 output fix_valid, output last_of_sentence, input ready);
  modport sink(input valid, input field_sel, input char_pos, input coord_char,
               input fix_valid, input last_of_sentence, output ready);
endinterface
`default_nettype wire

@@ hdl/nrmc_parser.sv @@
`default_nettype none
`include "nmea_rmc_position_extractor_top_defines.svh"
module nrmc_parser #(
  parameter int LAT_LEN = 9,
  parameter int LON_LEN = 10
) (
  input  wire                     clk,
  input  wire                     rst_n,
  nrmc_in_if.sink                 in_ch,
  input  nrmc_pkg::fifo_stat_t    fifo_stat,
  output logic                    push,
  output nrmc_pkg::coord_rec_t    rec
);

  nrmc_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]       count_r, count_nxt;
  logic             flag_r, flag_nxt;
  logic             fire;
  logic             is_lon;
  logic [4:0]       field_len;
  logic [4:0]       count_inc;
  logic             last;
  logic [7:0]       b;

  assign in_ch.ready = !fifo_stat.full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;

  assign is_lon    = (phase_r == nrmc_pkg::PH_LON);
  assign field_len = is_lon ? 5'(LON_LEN) : 5'(LAT_LEN);
  assign count_inc = {1'b0, count_r} + 5'd1;
  assign last      = (count_inc >= field_len);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    flag_nxt  = flag_r;
    if (fire) begin
      case (phase_r)
        nrmc_pkg::PH_HUNT: begin
          if (b == nrmc_pkg::CH_DOLLAR) phase_nxt = nrmc_pkg::PH_G;
        end
        nrmc_pkg::PH_G, nrmc_pkg::PH_P, nrmc_pkg::PH_R, nrmc_pkg::PH_M,
        nrmc_pkg::PH_C: begin
          if (b == nrmc_pkg::header_char(phase_r)) begin
            phase_nxt = nrmc_pkg::phase_t'(phase_r + 4'd1);
          end else begin
            phase_nxt = nrmc_pkg::PH_HUNT;
          end
        end
        nrmc_pkg::PH_SKIP1, nrmc_pkg::PH_SKIP2, nrmc_pkg::PH_SKIP3,
        nrmc_pkg::PH_SKIPL1: begin
          if (b == nrmc_pkg::CH_COMMA) phase_nxt = nrmc_pkg::phase_t'(phase_r + 4'd1);
        end
        nrmc_pkg::PH_SKIPL2: begin
          if (b == nrmc_pkg::CH_COMMA) begin
            phase_nxt = nrmc_pkg::PH_LON;
            count_nxt = '0;
          end
        end
        nrmc_pkg::PH_STATUS: begin
          count_nxt = '0;
          if (b == nrmc_pkg::CH_A) begin
            flag_nxt  = 1'b1;
            phase_nxt = nrmc_pkg::PH_SKIP3;
          end else if (b == nrmc_pkg::CH_V) begin
            flag_nxt  = 1'b0;
            phase_nxt = nrmc_pkg::PH_SKIP3;
          end else begin
            phase_nxt = nrmc_pkg::PH_HUNT;
          end
        end
        nrmc_pkg::PH_LAT, nrmc_pkg::PH_LON: begin
          if (last) begin
            count_nxt = '0;
            phase_nxt = is_lon ? nrmc_pkg::PH_HUNT : nrmc_pkg::PH_SKIPL1;
          end else begin
            count_nxt = count_inc[3:0];
          end
        end
        default: begin
          phase_nxt = nrmc_pkg::PH_HUNT;
          count_nxt = '0;
        end
      endcase
    end
  end

  // outputs: a record only for coordinate bytes
  always_comb begin
    push                 = 1'b0;
    rec.field_sel        = is_lon;
    rec.char_pos         = count_r;
    rec.coord_char       = b;
    rec.fix_valid        = flag_r;
    rec.last_of_sentence = is_lon && last;
    case (phase_r)
      nrmc_pkg::PH_LAT, nrmc_pkg::PH_LON: push = fire;
      default:                            push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= nrmc_pkg::PH_HUNT;
      count_r <= '0;
      flag_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      flag_r  <= flag_nxt;
    end
  end

  `NRMC_ASSERT_IMP(a_last_only_lon, push, !rec.last_of_sentence || rec.field_sel)
  `NRMC_ASSERT_NXT(a_hunt_after_last, push && rec.last_of_sentence,
                   phase_r == nrmc_pkg::PH_HUNT && count_r == 4'd0)
  `NRMC_ASSERT_IMP(a_lat_pos_bound, push && !rec.field_sel, rec.char_pos <= 4'(LAT_LEN - 1))

endmodule
`default_nettype wire

@@ hdl/nrmc_fifo.sv @@
`default_nettype none
`include "nmea_rmc_position_extractor_top_defines.svh"
module nrmc_fifo (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     push,
  input  nrmc_pkg::coord_rec_t    wr_data,
  input  wire                     pop,
  output nrmc_pkg::coord_rec_t    rd_data,
  output nrmc_pkg::fifo_stat_t    stat
);

  nrmc_pkg::coord_rec_t                mem_r [nrmc_pkg::FIFO_DEPTH];
  logic [nrmc_pkg::FIFO_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [nrmc_pkg::FIFO_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [nrmc_pkg::FIFO_CNT_W-1:0]     count_r, count_nxt;
  logic                                do_push, do_pop;

  localparam logic [nrmc_pkg::FIFO_PTR_W-1:0] LAST_IDX =
    nrmc_pkg::FIFO_PTR_W'(nrmc_pkg::FIFO_DEPTH - 1);
  localparam logic [nrmc_pkg::FIFO_CNT_W-1:0] DEPTH_CNT =
    nrmc_pkg::FIFO_CNT_W'(nrmc_pkg::FIFO_DEPTH);

  assign stat.full  = (count_r == DEPTH_CNT);
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `NRMC_ASSERT_IMP(a_count_bound, 1'b1, count_r <= DEPTH_CNT)
  `NRMC_ASSERT_IMP(a_no_push_full, stat.full, !push)

endmodule
`default_nettype wire

@@ hdl/nrmc_out_stage.sv @@
`default_nettype none
module nrmc_out_stage (
  input  wire                     clk,
  input  wire                     rst_n,
  input  nrmc_pkg::fifo_stat_t    fifo_stat,
  input  nrmc_pkg::coord_rec_t    rd_data,
  output logic                    pop,
  nrmc_out_if.source              out_ch
);

  logic                 valid_r, valid_nxt;
  nrmc_pkg::coord_rec_t data_r;

  // refill whenever the queue holds an entry and the output register is free or being drained this cycle
  assign pop       = !fifo_stat.empty && (!valid_r || out_ch.ready);
  assign valid_nxt = pop || (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) data_r <= rd_data;
  end

  assign out_ch.valid            = valid_r;
  assign out_ch.field_sel        = data_r.field_sel;
  assign out_ch.char_pos         = data_r.char_pos;
  assign out_ch.coord_char       = data_r.coord_char;
  assign out_ch.fix_valid        = data_r.fix_valid;
  assign out_ch.last_of_sentence = data_r.last_of_sentence;

endmodule
`default_nettype wire

@@ hdl/nmea_rmc_position_extractor_top.sv @@
`default_nettype none
// GPRMC position extractor: takes one GPS byte per transaction and, once a
// "$GPRMC" header and a status byte of 'A' or 'V' have been seen, passes on the
// LAT_LEN latitude bytes and then the LON_LEN longitude bytes, each tagged with
// field, position, fix flag and (on the final longitude byte) an end marker;
// all other bytes are consumed silently. A byte is accepted every cycle while
// the two-entry queue behind the parser has room, so the block sustains one
// byte per cycle whenever the output side keeps taking results; that rate is
// set by the parser state update. A result passes through the queue write and
// then the output register load; that load waits while the output is stalled.
module nmea_rmc_position_extractor_top #(
  parameter int LAT_LEN = 9,
  parameter int LON_LEN = 10
) (
  input  wire         clk,
  input  wire         rst_n,
  nrmc_in_if.sink     in_ch,
  nrmc_out_if.source  out_ch
);

  logic                 push;
  logic                 pop;
  nrmc_pkg::coord_rec_t wr_rec;
  nrmc_pkg::coord_rec_t rd_rec;
  nrmc_pkg::fifo_stat_t fifo_stat;

  nrmc_parser #(
    .LAT_LEN(LAT_LEN),
    .LON_LEN(LON_LEN)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .fifo_stat (fifo_stat),
    .push      (push),
    .rec       (wr_rec)
  );

  nrmc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_rec),
    .pop     (pop),
    .rd_data (rd_rec),
    .stat    (fifo_stat)
  );

  nrmc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_stat (fifo_stat),
    .rd_data   (rd_rec),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire
